FILE: src/bcg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery charge gauge package
// Status codes, register indexes, result type and the voltage-to-percent
// lookup tables shared by the gauge logic.
// ----------------------------------------------------------------------------
package bcg_pkg;

    localparam int SAMPLES_PER_UPDATE_DEF = 6;

    localparam int MV_W     = 16;
    localparam int PCT_W    = 7;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 3;

    // Charge status codes.
    localparam logic [STATUS_W-1:0] ST_UNKNOWN      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CHARGING     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DISCHARGING  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_CHARGING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_DIS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_ADP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_USB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_DISABLED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPTER_WIRED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_USB_WIRED    = 3'd5;

    // A full charge is reported at or above this percent.
    localparam logic [PCT_W-1:0] FULL_PCT = 7'd99;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PCT_W-1:0]    percent;
        logic [MV_W-1:0]     voltage_mv;
        logic                adapter_online;
        logic                usb_online;
        logic                percent_changed;
    } result_t;

    // Outcome of a status derivation: the online latches and the status.
    typedef struct packed {
        logic                adapter_online;
        logic                usb_online;
        logic [STATUS_W-1:0] status;
    } derive_t;

    localparam int CHG_ROWS = 38;
    localparam int DIS_ROWS = 39;

    localparam logic [11:0] CHG_MV [0:CHG_ROWS-1] = '{
        12'd4050, 12'd4040, 12'd4020, 12'd4010, 12'd3990, 12'd3980, 12'd3970,
        12'd3960, 12'd3950, 12'd3940, 12'd3930, 12'd3920, 12'd3910, 12'd3900,
        12'd3890, 12'd3860, 12'd3830, 12'd3780, 12'd3760, 12'd3740, 12'd3720,
        12'd3700, 12'd3680, 12'd3660, 12'd3640, 12'd3620, 12'd3600, 12'd3580,
        12'd3560, 12'd3540, 12'd3520, 12'd3500, 12'd3480, 12'd3460, 12'd3440,
        12'd3430, 12'd3420, 12'd3020
    };

    localparam logic [PCT_W-1:0] CHG_PCT [0:CHG_ROWS-1] = '{
        7'd99, 7'd98, 7'd97, 7'd96, 7'd95, 7'd94, 7'd93,
        7'd92, 7'd91, 7'd90, 7'd85, 7'd81, 7'd77, 7'd73,
        7'd70, 7'd65, 7'd60, 7'd55, 7'd50, 7'd45, 7'd40,
        7'd35, 7'd30, 7'd25, 7'd20, 7'd17, 7'd14, 7'd13,
        7'd12, 7'd11, 7'd10, 7'd9, 7'd8, 7'd7, 7'd6,
        7'd5, 7'd4, 7'd0
    };

    localparam logic [11:0] DIS_MV [0:DIS_ROWS-1] = '{
        12'd4050, 12'd4035, 12'd4020, 12'd4010, 12'd4000, 12'd3990, 12'd3980,
        12'd3970, 12'd3960, 12'd3950, 12'd3940, 12'd3930, 12'd3920, 12'd3910,
        12'd3900, 12'd3890, 12'd3860, 12'd3830, 12'd3780, 12'd3760, 12'd3740,
        12'd3720, 12'd3700, 12'd3680, 12'd3660, 12'd3640, 12'd3620, 12'd3600,
        12'd3580, 12'd3560, 12'd3540, 12'd3520, 12'd3500, 12'd3480, 12'd3460,
        12'd3440, 12'd3430, 12'd3420, 12'd3020
    };

    localparam logic [PCT_W-1:0] DIS_PCT [0:DIS_ROWS-1] = '{
        7'd100, 7'd99, 7'd98, 7'd97, 7'd96, 7'd96, 7'd95,
        7'd92, 7'd91, 7'd90, 7'd88, 7'd86, 7'd84, 7'd82,
        7'd80, 7'd74, 7'd69, 7'd64, 7'd59, 7'd54, 7'd49,
        7'd44, 7'd39, 7'd34, 7'd29, 7'd24, 7'd19, 7'd14,
        7'd13, 7'd12, 7'd11, 7'd10, 7'd9, 7'd8, 7'd7,
        7'd6, 7'd5, 7'd4, 7'd0
    };

    // The first row whose voltage does not exceed mv wins; scanning from the
    // bottom lets earlier rows override later ones.
    function automatic logic [PCT_W-1:0] chg_lookup(input logic [MV_W-1:0] mv);
        logic [PCT_W-1:0] pct;
        pct = '0;
        for (int i = CHG_ROWS - 1; i >= 0; i--) begin
            if (mv >= {4'd0, CHG_MV[i]}) begin
                pct = CHG_PCT[i];
            end
        end
        return pct;
    endfunction

    function automatic logic [PCT_W-1:0] dis_lookup(input logic [MV_W-1:0] mv);
        logic [PCT_W-1:0] pct;
        pct = '0;
        for (int i = DIS_ROWS - 1; i >= 0; i--) begin
            if (mv >= {4'd0, DIS_MV[i]}) begin
                pct = DIS_PCT[i];
            end
        end
        return pct;
    endfunction

endpackage
`default_nettype wire

FILE: src/battery_charge_gauge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery charge gauge
// Tracks charger presence from the active-low pins, accumulates offset
// corrected voltage samples and derives charge status and capacity percent.
// ----------------------------------------------------------------------------
//  Channel   Ports                    Handshake
//  input     s_valid / s_ready, s_*   transaction when valid and ready are high
//  result    m_valid / m_ready, m_*   transaction when valid and ready are high
//  config    cfg_wr_en, cfg_index     write at the edge where cfg_wr_en is high
//
//  One input is taken per cycle while s_ready is high; its result is registered.
//  All work for an item sits between the state registers and a two-entry
//  result buffer, so input is taken while one result waits on m_ready.
//  s_ready drops only when both result entries are held.
//  Synchronous active-low reset returns state and configuration to defaults.
// ----------------------------------------------------------------------------
module battery_charge_gauge
    import bcg_pkg::*;
#(
    parameter int SAMPLES_PER_UPDATE = SAMPLES_PER_UPDATE_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,

    input  wire                  cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [MV_W-1:0]       cfg_wdata,

    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire                  s_kind,
    input  wire                  s_adapter_ok_level,
    input  wire                  s_usb_ok_level,
    input  wire                  s_charge_level,
    input  wire [MV_W-1:0]       s_sample_mv,

    output logic                 m_valid,
    input  wire                  m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [PCT_W-1:0]     m_percent,
    output logic [MV_W-1:0]      m_voltage_mv,
    output logic                 m_adapter_online,
    output logic                 m_usb_online,
    output logic                 m_percent_changed
);

    localparam int CNT_W = $clog2(SAMPLES_PER_UPDATE + 1);
    localparam int SUM_W = MV_W + $clog2(SAMPLES_PER_UPDATE + 1);

    // Division of the sum by the sample count uses a rounded-up reciprocal;
    // with this shift the quotient is exact for every sum of SUM_W bits.
    localparam int DIV_SHIFT = SUM_W + $clog2(SAMPLES_PER_UPDATE);
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + SAMPLES_PER_UPDATE - 1) / SAMPLES_PER_UPDATE;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_UPDATE);

    // Configuration registers.
    logic [MV_W-1:0] offset_dis_reg;
    logic [MV_W-1:0] offset_adp_reg;
    logic [MV_W-1:0] offset_usb_reg;
    logic            adc_disabled_reg;
    logic            adapter_wired_reg;
    logic            usb_wired_reg;

    // Gauge state.
    logic                adapter_present_reg, adapter_present_next;
    logic                usb_present_reg, usb_present_next;
    logic                charge_pin_reg, charge_pin_next;
    logic                adapter_online_reg, adapter_online_next;
    logic                usb_online_reg, usb_online_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PCT_W-1:0]    percent_reg, percent_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MV_W-1:0]     voltage_reg, voltage_next;

    // Result buffer.
    result_t     slot0_reg, slot0_next;
    result_t     slot1_reg, slot1_next;
    logic [1:0]  count_reg, count_next;

    logic             push, pop;
    logic             pin_adapter, pin_usb, moved;
    logic             der_adapter, der_usb, der_charge;
    derive_t          derived;
    logic             do_derive;
    logic [MV_W-1:0]  offset_sel;
    logic [MV_W-1:0]  corrected;
    logic [SUM_W-1:0] sum_acc;
    logic [CNT_W-1:0] cnt_inc;
    logic             update;
    logic [PROD_W-1:0] product;
    logic [MV_W-1:0]  average;
    logic [PCT_W-1:0] table_pct;
    logic             changed;
    result_t          result;

    assign push = s_valid && s_ready;
    assign pop  = m_valid && m_ready;

    assign s_ready = (count_reg != 2'd2);
    assign m_valid = (count_reg != 2'd0);

    // Pin decoding.
    assign pin_adapter = adapter_wired_reg && !s_adapter_ok_level;
    assign pin_usb     = usb_wired_reg && !s_usb_ok_level;
    assign moved = (pin_adapter != adapter_present_reg) || (pin_usb != usb_present_reg);

    // Sample path.
    always_comb begin
        if (!adapter_online_reg && !usb_online_reg) begin
            offset_sel = offset_dis_reg;
        end else if (usb_online_reg) begin
            offset_sel = offset_usb_reg;
        end else begin
            offset_sel = offset_adp_reg;
        end
    end

    assign corrected = (s_sample_mv > offset_sel) ? (s_sample_mv - offset_sel) : '0;
    assign sum_acc   = adc_disabled_reg ? sum_reg : (sum_reg + SUM_W'(corrected));
    assign cnt_inc   = cnt_reg + 1'b1;
    assign update    = s_kind && (cnt_inc == CNT_LAST);

    // One derivation unit serves both the pin and the sample path; a pin item
    // derives with the new levels, a sample item with the stored ones.
    assign der_adapter = s_kind ? adapter_present_reg : pin_adapter;
    assign der_usb     = s_kind ? usb_present_reg : pin_usb;
    assign der_charge  = s_kind ? charge_pin_reg : s_charge_level;
    assign do_derive   = s_kind ? update : moved;

    always_comb begin
        derived.adapter_online = adapter_online_reg;
        derived.usb_online     = usb_online_reg;
        derived.status         = status_reg;
        // A set latch is kept while the other charger is still present.
        if (der_adapter) begin
            derived.adapter_online = 1'b1;
        end else if (der_usb) begin
            derived.usb_online = 1'b1;
        end else begin
            derived.adapter_online = 1'b0;
            derived.usb_online     = 1'b0;
        end
        if (!derived.adapter_online && !derived.usb_online) begin
            derived.status = ST_DISCHARGING;
        end else if (!der_charge) begin
            derived.status = ST_CHARGING;
        end else if (der_adapter || der_usb) begin
            if (adc_disabled_reg || percent_reg >= FULL_PCT) begin
                derived.status = ST_FULL;
            end else begin
                derived.status = ST_NOT_CHARGING;
            end
        end
    end

    assign product   = PROD_W'(sum_acc) * PROD_W'(RECIP_W'(RECIP_FULL));
    assign average   = product[DIV_SHIFT +: MV_W];
    assign table_pct = (derived.status == ST_DISCHARGING) ? dis_lookup(average)
                                                          : chg_lookup(average);

    always_comb begin
        adapter_present_next = adapter_present_reg;
        usb_present_next     = usb_present_reg;
        charge_pin_next      = charge_pin_reg;
        adapter_online_next  = adapter_online_reg;
        usb_online_next      = usb_online_reg;
        status_next          = status_reg;
        percent_next         = percent_reg;
        sum_next             = sum_reg;
        cnt_next             = cnt_reg;
        voltage_next         = voltage_reg;
        changed              = 1'b0;
        if (push) begin
            if (do_derive) begin
                adapter_online_next = derived.adapter_online;
                usb_online_next     = derived.usb_online;
                status_next         = derived.status;
            end
            if (!s_kind) begin
                adapter_present_next = pin_adapter;
                usb_present_next     = pin_usb;
                charge_pin_next      = s_charge_level;
            end else if (update) begin
                if (!adc_disabled_reg) begin
                    voltage_next = average;
                    percent_next = table_pct;
                    changed      = (table_pct != percent_reg);
                end
                sum_next = '0;
                cnt_next = '0;
            end else begin
                sum_next = sum_acc;
                cnt_next = cnt_inc;
            end
        end
    end

    always_comb begin
        result.status          = status_next;
        result.percent         = percent_next;
        result.voltage_mv      = voltage_next;
        result.adapter_online  = adapter_online_next;
        result.usb_online      = usb_online_next;
        result.percent_changed = changed;
    end

    // Two-entry result buffer: slot0 drives the outputs.
    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (pop && !push) begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end else if (push && !pop) begin
            if (count_reg == 2'd0) begin
                slot0_next = result;
            end else begin
                slot1_next = result;
            end
            count_next = count_reg + 2'd1;
        end else if (push && pop) begin
            if (count_reg == 2'd1) begin
                slot0_next = result;
            end else begin
                slot0_next = slot1_reg;
                slot1_next = result;
            end
        end
    end

    assign m_status          = slot0_reg.status;
    assign m_percent         = slot0_reg.percent;
    assign m_voltage_mv      = slot0_reg.voltage_mv;
    assign m_adapter_online  = slot0_reg.adapter_online;
    assign m_usb_online      = slot0_reg.usb_online;
    assign m_percent_changed = slot0_reg.percent_changed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_dis_reg    <= '0;
            offset_adp_reg    <= '0;
            offset_usb_reg    <= '0;
            adc_disabled_reg  <= 1'b0;
            adapter_wired_reg <= 1'b1;
            usb_wired_reg     <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OFFSET_DIS:    offset_dis_reg    <= cfg_wdata;
                CFG_OFFSET_ADP:    offset_adp_reg    <= cfg_wdata;
                CFG_OFFSET_USB:    offset_usb_reg    <= cfg_wdata;
                CFG_ADC_DISABLED:  adc_disabled_reg  <= cfg_wdata[0];
                CFG_ADAPTER_WIRED: adapter_wired_reg <= cfg_wdata[0];
                CFG_USB_WIRED:     usb_wired_reg     <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adapter_present_reg <= 1'b0;
            usb_present_reg     <= 1'b0;
            charge_pin_reg      <= 1'b1;
            adapter_online_reg  <= 1'b0;
            usb_online_reg      <= 1'b0;
            status_reg          <= ST_UNKNOWN;
            percent_reg         <= '0;
            sum_reg             <= '0;
            cnt_reg             <= '0;
            voltage_reg         <= '0;
            count_reg           <= 2'd0;
        end else begin
            adapter_present_reg <= adapter_present_next;
            usb_present_reg     <= usb_present_next;
            charge_pin_reg      <= charge_pin_next;
            adapter_online_reg  <= adapter_online_next;
            usb_online_reg      <= usb_online_next;
            status_reg          <= status_next;
            percent_reg         <= percent_next;
            sum_reg             <= sum_next;
            cnt_reg             <= cnt_next;
            voltage_reg         <= voltage_next;
            count_reg           <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_cnt_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < CNT_LAST)
        else $error("sample counter reached the update count");

    a_pin_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !s_kind) |=> ($stable(cnt_reg) && $stable(sum_reg)))
        else $error("pin transaction disturbed the sample accumulator");

    a_pin_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !s_kind) |=> $stable(percent_reg))
        else $error("pin transaction changed the capacity percent");

    a_update_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && update) |=> (cnt_reg == '0 && sum_reg == '0))
        else $error("accumulator not cleared after an update");

endmodule
`default_nettype wire
